FILE: rtl/ataic_pkg.sv
`default_nettype none

package ataic_pkg;

  // Identify block geometry
  localparam int unsigned IdWords   = 256;
  localparam int unsigned IdxW      = $clog2(IdWords);

  // Identify word positions that are captured, and the last word position
  localparam logic [IdxW-1:0] WordCaps    = IdxW'(53);
  localparam logic [IdxW-1:0] WordLba28Lo = IdxW'(60);
  localparam logic [IdxW-1:0] WordLba28Hi = IdxW'(61);
  localparam logic [IdxW-1:0] WordMwdmaA  = IdxW'(62);
  localparam logic [IdxW-1:0] WordMwdmaB  = IdxW'(63);
  localparam logic [IdxW-1:0] WordCmdSet  = IdxW'(83);
  localparam logic [IdxW-1:0] WordUdma    = IdxW'(88);
  localparam logic [IdxW-1:0] WordLba48_0 = IdxW'(100);
  localparam logic [IdxW-1:0] WordLba48_1 = IdxW'(101);
  localparam logic [IdxW-1:0] WordLba48_2 = IdxW'(102);
  localparam logic [IdxW-1:0] WordLba48_3 = IdxW'(103);
  localparam logic [IdxW-1:0] WordLast    = IdxW'(IdWords - 1);

  // Signature bytes
  localparam logic [7:0] SigAtapiMid = 8'h14;
  localparam logic [7:0] SigAtapiHigh = 8'hEB;
  localparam logic [7:0] SigSataMid  = 8'h3C;
  localparam logic [7:0] SigSataHigh = 8'hC3;

  // Bit positions
  localparam int unsigned StatusErrBit = 0;
  localparam int unsigned Lba48Bit     = 10;

  typedef enum logic {
    ReqProbe = 1'b0,
    ReqData  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    DriveNone  = 2'd0,
    DriveAta   = 2'd1,
    DriveAtapi = 2'd2,
    DriveSata  = 2'd3
  } drive_type_e;

  typedef struct packed {
    logic [1:0]  slot;
    drive_type_e drive_type;
    logic        udma_active;
    logic        dma_active;
    logic        lba28_supported;
    logic        lba48_supported;
    logic [63:0] max_sector;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/ataic_classify.sv
`default_nettype none

module ataic_classify
  import ataic_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic        req_type_i,
  input  wire logic [1:0]  drive_slot_i,
  input  wire logic [7:0]  first_status_i,
  input  wire logic [7:0]  sig_mid_i,
  input  wire logic [7:0]  sig_high_i,
  input  wire logic [7:0]  ready_status_i,
  input  wire logic [15:0] data_word_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  logic            collecting_q, collecting_d;
  logic [IdxW-1:0] word_index_q, word_index_d;
  logic [1:0]      slot_held_q, slot_held_d;
  logic [1:0]      caps_q, caps_d;
  logic            udma_seen_q, udma_seen_d;
  logic            mwdma_seen_q, mwdma_seen_d;
  logic            lba48_flag_q, lba48_flag_d;
  logic [31:0]     lba28_q, lba28_d;
  logic [63:0]     lba48_q, lba48_d;
  logic            hi_byte_set;
  logic            lba28_nz;

  assign hi_byte_set = (data_word_i[15:8] != 8'h00);
  assign lba28_nz    = (lba28_d != 32'd0);

  // Classify probes, capture identify words, build the result
  always_comb begin
    collecting_d = collecting_q;
    word_index_d = word_index_q;
    slot_held_d  = slot_held_q;
    caps_d       = caps_q;
    udma_seen_d  = udma_seen_q;
    mwdma_seen_d = mwdma_seen_q;
    lba48_flag_d = lba48_flag_q;
    lba28_d      = lba28_q;
    lba48_d      = lba48_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    res_o.slot   = drive_slot_i;
    res_o.drive_type = DriveNone;

    if (fire_i) begin
      if (req_type_i == ReqProbe) begin
        // Drop any unfinished collection and start over
        collecting_d = 1'b0;
        word_index_d = '0;
        caps_d       = '0;
        udma_seen_d  = 1'b0;
        mwdma_seen_d = 1'b0;
        lba48_flag_d = 1'b0;
        lba28_d      = '0;
        lba48_d      = '0;
        slot_held_d  = drive_slot_i;
        res_valid_o  = 1'b1;
        if (first_status_i != 8'h00) begin
          if (sig_mid_i != 8'h00 || sig_high_i != 8'h00) begin
            if (sig_mid_i == SigAtapiMid && sig_high_i == SigAtapiHigh) begin
              res_o.drive_type = DriveAtapi;
            end else if (sig_mid_i == SigSataMid && sig_high_i == SigSataHigh) begin
              res_o.drive_type = DriveSata;
            end
          end else if (!ready_status_i[StatusErrBit]) begin
            collecting_d = 1'b1;
            res_valid_o  = 1'b0;
          end
        end
      end else if (collecting_q) begin
        // Capture the words of interest
        unique case (word_index_q)
          WordCaps:    caps_d = data_word_i[2:1];
          WordLba28Lo: lba28_d[15:0] = data_word_i;
          WordLba28Hi: lba28_d[31:16] = data_word_i;
          WordMwdmaA,
          WordMwdmaB:  mwdma_seen_d = mwdma_seen_q | hi_byte_set;
          WordCmdSet:  lba48_flag_d = data_word_i[Lba48Bit];
          WordUdma:    udma_seen_d = hi_byte_set;
          WordLba48_0: lba48_d[15:0] = data_word_i;
          WordLba48_1: lba48_d[31:16] = data_word_i;
          WordLba48_2: lba48_d[47:32] = data_word_i;
          WordLba48_3: lba48_d[63:48] = data_word_i;
          default: ;
        endcase

        // Report after the last word
        if (word_index_q == WordLast) begin
          res_valid_o           = 1'b1;
          res_o.slot            = slot_held_q;
          res_o.drive_type      = DriveAta;
          res_o.udma_active     = caps_d[1] & udma_seen_d;
          res_o.dma_active      = caps_d[0] & mwdma_seen_d;
          res_o.lba28_supported = lba28_nz;
          res_o.lba48_supported = lba48_flag_d;
          if (lba28_nz) begin
            res_o.max_sector = {32'd0, lba28_d};
          end else if (lba48_flag_d) begin
            res_o.max_sector = lba48_d;
          end
          collecting_d = 1'b0;
          word_index_d = '0;
        end else begin
          word_index_d = word_index_q + IdxW'(1);
        end
      end
    end
  end

  // Hold collection state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      word_index_q <= '0;
      slot_held_q  <= '0;
      caps_q       <= '0;
      udma_seen_q  <= 1'b0;
      mwdma_seen_q <= 1'b0;
      lba48_flag_q <= 1'b0;
      lba28_q      <= '0;
      lba48_q      <= '0;
    end else begin
      collecting_q <= collecting_d;
      word_index_q <= word_index_d;
      slot_held_q  <= slot_held_d;
      caps_q       <= caps_d;
      udma_seen_q  <= udma_seen_d;
      mwdma_seen_q <= mwdma_seen_d;
      lba48_flag_q <= lba48_flag_d;
      lba28_q      <= lba28_d;
      lba48_q      <= lba48_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ata_identify_classifier_unit.sv
`default_nettype none

// Channel | Direction | Handshake               | Word
// --------+-----------+-------------------------+------------------------------------
// in      | input     | in_valid_i / in_stall_o | probe response or one identify word
// out     | output    | out_valid_o/out_stall_i | drive classification
//
// One word is taken per cycle while in_stall_o is low; a word is held in
// the input register, its result in the result register. The capture path
// is a single index decode plus a 32-bit zero test and a 64-bit select.
// Reset clears both stage valids and all collection state.
// A stalled result stalls input only when the input register also holds a word.

module ata_identify_classifier_unit
  import ataic_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [1:0]  drive_slot_i,
  input  wire logic [7:0]  first_status_i,
  input  wire logic [7:0]  sig_mid_i,
  input  wire logic [7:0]  sig_high_i,
  input  wire logic [7:0]  ready_status_i,
  input  wire logic [15:0] data_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_slot_o,
  output logic [1:0]       drive_type_o,
  output logic             udma_active_o,
  output logic             dma_active_o,
  output logic             lba28_supported_o,
  output logic             lba48_supported_o,
  output logic [63:0]      max_sector_o
);

  logic        in_valid_q, in_valid_d;
  logic        req_type_q;
  logic [1:0]  drive_slot_q;
  logic [7:0]  first_status_q;
  logic [7:0]  sig_mid_q;
  logic [7:0]  sig_high_q;
  logic [7:0]  ready_status_q;
  logic [15:0] data_word_q;
  logic        advance;
  logic        in_take;
  logic        res_valid;
  result_t     res;
  logic        out_valid_q, out_valid_d;
  result_t     out_q;

  // Advance the held word when the result register can take a result
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_type_q     <= req_type_i;
      drive_slot_q   <= drive_slot_i;
      first_status_q <= first_status_i;
      sig_mid_q      <= sig_mid_i;
      sig_high_q     <= sig_high_i;
      ready_status_q <= ready_status_i;
      data_word_q    <= data_word_i;
    end
  end

  ataic_classify u_classify (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (advance),
    .req_type_i     (req_type_q),
    .drive_slot_i   (drive_slot_q),
    .first_status_i (first_status_q),
    .sig_mid_i      (sig_mid_q),
    .sig_high_i     (sig_high_q),
    .ready_status_i (ready_status_q),
    .data_word_i    (data_word_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // Load a new result or drop the one taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_slot_o     = out_q.slot;
  assign drive_type_o      = out_q.drive_type;
  assign udma_active_o     = out_q.udma_active;
  assign dma_active_o      = out_q.dma_active;
  assign lba28_supported_o = out_q.lba28_supported;
  assign lba48_supported_o = out_q.lba48_supported;
  assign max_sector_o      = out_q.max_sector;

  // Non-ATA results carry no capability bits and no size
  a_non_ata_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_type_o != DriveAta |->
      max_sector_o == 64'd0 && !udma_active_o && !dma_active_o &&
      !lba28_supported_o && !lba48_supported_o)
    else $error("non-ATA result with capability fields set");

  // An LBA28 size is a nonzero 32-bit count
  a_lba28_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lba28_supported_o |->
      max_sector_o[63:32] == 32'd0 && max_sector_o[31:0] != 32'd0)
    else $error("LBA28 result with bad sector count");

  // A result register that is stalled is not overwritten
  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_q))
    else $error("stalled result changed");

  // Input stalls only while a word is held
  a_stall_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with no held word");

endmodule

`default_nettype wire
